FILE: rtl/ptts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptts_pkg
// Shared types and constants for the periodic task tick scheduler.
// ----------------------------------------------------------------------------
package ptts_pkg;

   // default sizing
   localparam int NUM_TASKS_DEF  = 8;
   localparam int TICK_WIDTH_DEF = 16;

   // field widths fixed by the request/response format
   localparam int OP_W      = 3;
   localparam int ID_W      = 3;
   localparam int FIELD_W   = 16;
   localparam int MASK_W    = 8;

   // operation codes
   localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
   localparam logic [OP_W-1:0] OP_CREATE  = 3'd1;
   localparam logic [OP_W-1:0] OP_DELETE  = 3'd2;
   localparam logic [OP_W-1:0] OP_SUSPEND = 3'd3;
   localparam logic [OP_W-1:0] OP_RESUME  = 3'd4;

   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic [ID_W-1:0]    task_id;
      logic [FIELD_W-1:0] period;
      logic [FIELD_W-1:0] first_delay;
      logic               start_running;
   } req_type;

   typedef struct packed {
      logic [MASK_W-1:0] fire_mask;
      logic              op_accepted;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DONE
   } state_type;

endpackage

FILE: rtl/ptts_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ptts_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/ptts_dec_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptts_dec_unit
// Shared countdown unit: zero test, reload select and one decrementer.
// ----------------------------------------------------------------------------
module ptts_dec_unit #(
   parameter int WIDTH = 16
) (
   input  logic [WIDTH-1:0] countdown,
   input  logic [WIDTH-1:0] period,
   output logic [WIDTH-1:0] next_count,
   output logic             fire
);

   logic [WIDTH-1:0] operand;

   // fire on zero and reload with period - 1, else count down
   always_comb begin
      fire       = (countdown == '0);
      operand    = fire ? period : countdown;
      next_count = operand - WIDTH'(1);
   end

endmodule

FILE: rtl/periodic_task_tick_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler
// Time-triggered scheduler with a table of periodic task slots.
// ----------------------------------------------------------------------------
// Each request is one operation: tick, create, delete, suspend or resume.
// Create, delete, suspend and resume complete in the cycle the request is
// taken and their response is registered on the next edge. A tick walks the
// slot table through one shared decrementer, one slot per cycle, with period
// and countdown held in RAMs of registered read: each slot is read, then the
// countdown of a valid, running slot is written back, the walk closes and
// the tick result is loaded into the response register. Requests are
// stalled while a tick walks the table or waits to hand over its result, or
// while the response register is full and stalled. Slot valid and running
// bits are flip-flops cleared by reset; period and countdown are written by
// create, and countdown also by the write-back of the tick walk.
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler
   import ptts_pkg::*;
#(
   parameter int NUM_TASKS  = NUM_TASKS_DEF,
   parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
   localparam int CNT_W = $clog2(NUM_TASKS + 1);
   localparam logic [31:0] TICK_MAX = 32'((64'd1 << TICK_WIDTH) - 64'd1);

   state_type state_ff, state_in;

   logic [NUM_TASKS-1:0]  valid_ff, valid_in;
   logic [NUM_TASKS-1:0]  running_ff, running_in;
   logic [CNT_W-1:0]      walk_ff, walk_in;
   logic                  wb_valid_ff, wb_valid_in;
   logic [IDX_W-1:0]      wb_idx_ff, wb_idx_in;
   logic [MASK_W-1:0]     mask_ff, mask_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  req_accept;
   logic                  rsp_free;
   logic                  issue;
   logic                  walk_done;
   logic                  load_tick_rsp;

   logic                  in_range;
   logic [IDX_W-1:0]      slot;
   logic [31:0]           per_ext, dly_ext;
   logic [TICK_WIDTH-1:0] per_sat, dly_sat;

   logic [IDX_W-1:0]      rd_addr;
   logic [TICK_WIDTH-1:0] period_rd, count_rd;
   logic                  per_wr_en;
   logic                  cnt_wr_en;
   logic [IDX_W-1:0]      cnt_wr_addr;
   logic [TICK_WIDTH-1:0] cnt_wr_data;
   logic [TICK_WIDTH-1:0] dec_next;
   logic                  dec_fire;
   logic                  wb_active;
   logic [6:0]            wb_ext;

   // handshake terms
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // decode the addressed slot and saturate times to the tick width
   always_comb begin
      in_range = (7'(req_data.task_id) < 7'(NUM_TASKS));
      slot     = IDX_W'(req_data.task_id);
      per_ext  = 32'(req_data.period);
      dly_ext  = 32'(req_data.first_delay);
      per_sat  = TICK_WIDTH'((per_ext > TICK_MAX) ? TICK_MAX : per_ext);
      dly_sat  = TICK_WIDTH'((dly_ext > TICK_MAX) ? TICK_MAX : dly_ext);
   end

   // walk issue and completion
   assign issue     = (state_ff == ST_WALK) && (walk_ff < CNT_W'(NUM_TASKS));
   assign walk_done = (state_ff == ST_WALK) && !issue && !wb_valid_ff;
   assign rd_addr   = walk_ff[IDX_W-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && req_data.operation == OP_TICK) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (walk_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall     = 1'b1;
      load_tick_rsp = 1'b0;
      case (state_ff)
         ST_IDLE: req_stall     = !rsp_free;
         ST_WALK: req_stall     = 1'b1;
         ST_DONE: load_tick_rsp = rsp_free;
         default: req_stall     = 1'b1;
      endcase
   end

   // shared countdown unit
   ptts_dec_unit #(
      .WIDTH(TICK_WIDTH)
   ) u_dec (
      .countdown (count_rd),
      .period    (period_rd),
      .next_count(dec_next),
      .fire      (dec_fire)
   );

   ptts_ram #(
      .WIDTH(TICK_WIDTH),
      .DEPTH(NUM_TASKS)
   ) u_period_ram (
      .clock  (clock),
      .wr_en  (per_wr_en),
      .wr_addr(slot),
      .wr_data(per_sat),
      .rd_addr(rd_addr),
      .rd_data(period_rd)
   );

   ptts_ram #(
      .WIDTH(TICK_WIDTH),
      .DEPTH(NUM_TASKS)
   ) u_count_ram (
      .clock  (clock),
      .wr_en  (cnt_wr_en),
      .wr_addr(cnt_wr_addr),
      .wr_data(cnt_wr_data),
      .rd_addr(rd_addr),
      .rd_data(count_rd)
   );

   // slot table update, walk write-back and response build
   always_comb begin
      valid_in     = valid_ff;
      running_in   = running_ff;
      walk_in      = walk_ff;
      wb_valid_in  = 1'b0;
      wb_idx_in    = wb_idx_ff;
      mask_in      = mask_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      per_wr_en    = 1'b0;
      cnt_wr_en    = 1'b0;
      cnt_wr_addr  = wb_idx_ff;
      cnt_wr_data  = dec_next;
      wb_active    = wb_valid_ff && valid_ff[wb_idx_ff] && running_ff[wb_idx_ff];
      wb_ext       = 7'(wb_idx_ff);

      // advance the walk: read one slot, write back the previous one if valid and running
      if (issue) begin
         walk_in     = walk_ff + CNT_W'(1);
         wb_valid_in = 1'b1;
         wb_idx_in   = rd_addr;
      end
      if (wb_active) begin
         cnt_wr_en = 1'b1;
         if (dec_fire && wb_ext < 7'd8) begin
            mask_in[wb_ext[2:0]] = 1'b1;
         end
      end

      // hand the tick result to the response register
      if (load_tick_rsp) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.fire_mask   = mask_ff;
         rsp_data_in.op_accepted = 1'b1;
      end

      // execute the accepted request
      if (req_accept) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.fire_mask   = '0;
         rsp_data_in.op_accepted = 1'b0;
         case (req_data.operation)
            OP_TICK: begin
               rsp_valid_in = 1'b0;
               walk_in      = '0;
               mask_in      = '0;
            end
            OP_CREATE: begin
               if (in_range && !valid_ff[slot] && per_sat != '0) begin
                  valid_in[slot]          = 1'b1;
                  running_in[slot]        = req_data.start_running;
                  per_wr_en               = 1'b1;
                  cnt_wr_en               = 1'b1;
                  cnt_wr_addr             = slot;
                  cnt_wr_data             = dly_sat;
                  rsp_data_in.op_accepted = 1'b1;
               end
            end
            OP_DELETE: begin
               if (in_range && valid_ff[slot]) begin
                  valid_in[slot]          = 1'b0;
                  running_in[slot]        = 1'b0;
                  rsp_data_in.op_accepted = 1'b1;
               end
            end
            OP_SUSPEND: begin
               if (in_range) begin
                  running_in[slot] = 1'b0;
               end
               rsp_data_in.op_accepted = 1'b1;
            end
            OP_RESUME: begin
               if (in_range) begin
                  running_in[slot] = 1'b1;
               end
               rsp_data_in.op_accepted = 1'b1;
            end
            default: rsp_data_in.op_accepted = 1'b0;
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         running_ff   <= '0;
         wb_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         running_ff   <= running_in;
         wb_valid_ff  <= wb_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      walk_ff     <= walk_in;
      wb_idx_ff   <= wb_idx_in;
      mask_ff     <= mask_in;
      rsp_data_ff <= rsp_data_in;
   end

   // requests are taken only from idle
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> state_ff == ST_IDLE)
      else $error("request accepted outside idle");

   // write-back only happens during the table walk
   a_wb_in_walk: assert property (@(posedge clock) disable iff (reset)
      wb_valid_ff |-> state_ff == ST_WALK)
      else $error("write-back outside table walk");

   // slot allocation is frozen while a tick is in progress
   a_valid_frozen: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |=> $stable(valid_ff))
      else $error("slot valid changed during tick");

   // a response with firings is always an accepted tick
   a_mask_accepted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.fire_mask != '0 |-> rsp_data_ff.op_accepted)
      else $error("fire mask on refused operation");

   // the response register never loads from two sources at once
   a_single_load: assert property (@(posedge clock) disable iff (reset)
      load_tick_rsp |-> !req_accept)
      else $error("tick result and request collide");

endmodule
